/* design/pf_pkg.sv */
// Package for the Playfair digraph cipher: grid sizes, types, register codes.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package pf_pkg;

  localparam int GRID_SIZE = 5;
  localparam int KEY_ROWS  = 5;
  localparam int KEY_COLS  = 5;
  localparam int CHAR_W    = 8;
  localparam int ROW_W     = KEY_COLS * CHAR_W;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int CFG_IDX_W = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ROW_W-1:0]  key_row_t;
  typedef key_row_t [KEY_ROWS-1:0] key_t;
  typedef char_t [GRID_SIZE-1:0][GRID_SIZE-1:0] grid_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ROW_0 = CFG_IDX_W'(0),
    REG_KEY_ROW_1 = CFG_IDX_W'(1),
    REG_KEY_ROW_2 = CFG_IDX_W'(2),
    REG_KEY_ROW_3 = CFG_IDX_W'(3),
    REG_KEY_ROW_4 = CFG_IDX_W'(4)
  } cfg_reg_e;

  typedef struct packed {
    char_t first;
    char_t second;
    logic  not_found;
  } xform_res_t;

  // Cells outside the stored rows and columns read as zero.
  function automatic grid_t build_grid(key_t key);
    grid_t g;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        if (r < KEY_ROWS && c < KEY_COLS) begin
          g[r][c] = key[r][c*CHAR_W +: CHAR_W];
        end else begin
          g[r][c] = '0;
        end
      end
    end
    return g;
  endfunction

  function automatic idx_t idx_inc(idx_t v);
    return (v == idx_t'(GRID_SIZE - 1)) ? '0 : idx_t'(v + idx_t'(1));
  endfunction

  function automatic idx_t idx_dec(idx_t v);
    return (v == '0) ? idx_t'(GRID_SIZE - 1) : idx_t'(v - idx_t'(1));
  endfunction

endpackage

`default_nettype wire

/* design/pf_if.sv */
// Valid/ready channel interfaces for the Playfair digraph cipher.
// Depends on pf_pkg.
`default_nettype none

interface pf_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  pf_pkg::char_t     first_char;
  pf_pkg::char_t     second_char;
  logic              last_pair;
  modport source (output valid, action, first_char, second_char, last_pair, input ready);
  modport sink   (input valid, action, first_char, second_char, last_pair, output ready);
endinterface

interface pf_out_if;
  logic              valid;
  logic              ready;
  pf_pkg::char_t     out_first;
  pf_pkg::char_t     out_second;
  logic              not_found;
  logic              out_last;
  modport source (output valid, out_first, out_second, not_found, out_last, input ready);
  modport sink   (input valid, out_first, out_second, not_found, out_last, output ready);
endinterface

interface pf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pf_pkg::CFG_IDX_W-1:0]        index;
  pf_pkg::key_row_t                    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

/* design/pf_locate.sv */
// Finds the row and column of one letter in the key grid; last match wins.
// Depends on pf_pkg.
`default_nettype none

module pf_locate (
  input  pf_pkg::grid_t grid_i,
  input  pf_pkg::char_t ch_i,
  output pf_pkg::idx_t  row_o,
  output pf_pkg::idx_t  col_o,
  output logic          hit_o
);
  import pf_pkg::*;

  always_comb begin
    row_o = '0;
    col_o = '0;
    hit_o = 1'b0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        if (grid_i[r][c] == ch_i) begin
          row_o = idx_t'(r);
          col_o = idx_t'(c);
          hit_o = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/pf_xform.sv */
// Digraph transform: locates both letters and applies the column, row or
// rectangle rule. Depends on pf_pkg and pf_locate.
`default_nettype none

module pf_xform (
  input  pf_pkg::grid_t      grid_i,
  input  logic               decrypt_i,
  input  pf_pkg::char_t      first_i,
  input  pf_pkg::char_t      second_i,
  output pf_pkg::xform_res_t res_o
);
  import pf_pkg::*;

  idx_t r1, c1, r2, c2;
  logic hit1, hit2;

  pf_locate u_loc_first (
    .grid_i (grid_i),
    .ch_i   (first_i),
    .row_o  (r1),
    .col_o  (c1),
    .hit_o  (hit1)
  );

  pf_locate u_loc_second (
    .grid_i (grid_i),
    .ch_i   (second_i),
    .row_o  (r2),
    .col_o  (c2),
    .hit_o  (hit2)
  );

  idx_t r1_step, r2_step, c1_step, c2_step;

  always_comb begin
    r1_step = decrypt_i ? idx_dec(r1) : idx_inc(r1);
    r2_step = decrypt_i ? idx_dec(r2) : idx_inc(r2);
    c1_step = decrypt_i ? idx_dec(c1) : idx_inc(c1);
    c2_step = decrypt_i ? idx_dec(c2) : idx_inc(c2);
  end

  always_comb begin
    res_o.first     = first_i;
    res_o.second    = second_i;
    res_o.not_found = 1'b0;
    priority if (!hit1 || !hit2) begin
      res_o.not_found = 1'b1;
    end else if (c1 == c2) begin
      res_o.first  = grid_i[r1_step][c1];
      res_o.second = grid_i[r2_step][c1];
    end else if (r1 == r2) begin
      res_o.first  = grid_i[r1][c1_step];
      res_o.second = grid_i[r1][c2_step];
    end else begin
      res_o.first  = grid_i[r1][c2];
      res_o.second = grid_i[r2][c1];
    end
  end

endmodule

`default_nettype wire

/* design/playfair_digraph_cipher.sv */
// Playfair digraph cipher, top level: key registers, input and result stages.
// Depends on pf_pkg, pf_if and pf_xform.
//
// Usage:
//   cfg_i  : register writes; index 0..4 selects key row 0..4 (column 0 in the
//            low byte). Always ready. Other indexes are ignored. Write only
//            while no item is in flight.
//   in_i   : one digraph per item (action 0 encrypt, 1 decrypt, two letter
//            bytes, last_pair flag).
//   out_o  : one result per item, in order: the transformed pair, not_found
//            set if either letter is missing (pair then passes unchanged),
//            and out_last copying last_pair.
// Path: an accepted item lands in the input register, and lookup and transform
//   load its result into the result register, which drives out_o.
// Throughput: one item per cycle while out_o is not held off; both letter
//   lookups run in parallel comparators against all 25 cells.
// Stall: while out_o is held off, the result register keeps its item and the
//   input register can still take one more; in_i.ready drops only when both
//   are full.
// Reset: clears both stage valid flags and all key rows to zero.
`default_nettype none

module playfair_digraph_cipher (
  input  logic      clk_i,
  input  logic      rst_ni,
  pf_cfg_if.sink    cfg_i,
  pf_in_if.sink     in_i,
  pf_out_if.source  out_o
);
  import pf_pkg::*;

  key_t       key_q;
  grid_t      grid;

  logic       s1_valid_q;
  logic       s1_action_q;
  char_t      s1_first_q;
  char_t      s1_second_q;
  logic       s1_last_q;

  logic       out_valid_q;
  xform_res_t out_res_q;
  logic       out_last_q;

  xform_res_t res_d;
  logic       s2_ready;
  logic       s1_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_KEY_ROW_0: key_q[0] <= cfg_i.wdata;
        REG_KEY_ROW_1: key_q[1] <= cfg_i.wdata;
        REG_KEY_ROW_2: key_q[2] <= cfg_i.wdata;
        REG_KEY_ROW_3: key_q[3] <= cfg_i.wdata;
        REG_KEY_ROW_4: key_q[4] <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign grid = build_grid(key_q);

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_action_q <= in_i.action;
      s1_first_q  <= in_i.first_char;
      s1_second_q <= in_i.second_char;
      s1_last_q   <= in_i.last_pair;
    end
  end

  pf_xform u_xform (
    .grid_i    (grid),
    .decrypt_i (s1_action_q),
    .first_i   (s1_first_q),
    .second_i  (s1_second_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_res_q  <= res_d;
      out_last_q <= s1_last_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_first  = out_res_q.first;
  assign out_o.out_second = out_res_q.second;
  assign out_o.not_found  = out_res_q.not_found;
  assign out_o.out_last   = out_last_q;

`ifndef SYNTHESIS
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_q)
    else $error("input stage item not moved to result stage");

  a_full_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && s1_valid_q |-> s2_ready)
    else $error("item accepted into full pipeline");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q && !out_valid_q |=> !out_valid_q)
    else $error("result appeared with no item in flight");
`endif

endmodule

`default_nettype wire
